FILE: sv/int_to_padded_decimal_ascii_macros.svh
// Assertion macros shared by the checker of the decimal ASCII formatter.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef INT_TO_PADDED_DECIMAL_ASCII_MACROS_SVH
`define INT_TO_PADDED_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define IPDA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define IPDA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ipda_pkg.sv
// Shared types, constants and state encodings of the decimal ASCII formatter.
// Has no dependencies; every module imports it.
package ipda_pkg;

  // Field and datapath sizes.
  localparam int VALUE_W       = 32;
  localparam int CHAR_W        = 8;
  localparam int DIGIT_W       = 4;
  localparam int NDIGITS       = 10;
  localparam int BCD_W         = NDIGITS * DIGIT_W;
  localparam int BITS_PER_STEP = 4;
  localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
  localparam int STEP_CNT_W    = $clog2(CONV_STEPS);
  localparam int DIG_IDX_W     = $clog2(NDIGITS);
  localparam int FW_W          = 4;
  localparam int BUF_W         = 8;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 8;

  localparam logic [DIGIT_W-1:0] MAX_FIELD = DIGIT_W'(NDIGITS);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PAD_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FIELD_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BUFFER_SIZE = 2'd2;

  // Reset values of the registers.
  localparam logic [BUF_W-1:0] BUFFER_SIZE_RST = 8'd255;

  // ASCII codes.
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;

  typedef logic [NDIGITS-1:0][DIGIT_W-1:0] bcd_t;

  // Register file contents handed to the character sequencer.
  typedef struct packed {
    logic             pad_mode;
    logic [FW_W-1:0]  field_width;
    logic [BUF_W-1:0] buffer_size;
  } cfg_t;

  // Converted value passed from the converter to the sequencer.
  typedef struct packed {
    logic neg;
    bcd_t bcd;
  } conv_res_t;

  typedef enum logic [1:0] {
    CV_IDLE,
    CV_RUN,
    CV_DONE
  } conv_state_t;

  typedef enum logic [2:0] {
    EM_IDLE,
    EM_PREP,
    EM_REJ,
    EM_SIGN,
    EM_BODY
  } emit_state_t;

endpackage

FILE: sv/int_to_padded_decimal_ascii.sv
// Signed 32-bit integer to padded decimal ASCII, one character per output beat.
// Depends on ipda_pkg, ipda_conv and ipda_emit.
// Input: one beat carries in_value, taken when in_valid is high and in_stall low.
// Output: a run of beats (out_char, out_last, out_ok); out_last marks the final
// character. A value whose text does not fit in buffer_size - 1 characters gives
// one beat with out_char zero, out_last high and out_ok low.
// Configuration: cfg_valid/cfg_ready write pad_mode, field_width or buffer_size
// by cfg_index; cfg_ready is always high and unknown indexes are ignored.
// Timing: the converter works through four magnitude bits per cycle and then
// hands its result over to the sequencer. The sequencer sizes the text, then
// sends its characters, and it overlaps with conversion of the next value.
// Reset clears the handshake state and sets the registers to pad_mode 0,
// field_width 0, buffer_size 255. A stall on the output holds the current beat;
// the converter keeps working and accepts one further value meanwhile.
module int_to_padded_decimal_ascii
  import ipda_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [CHAR_W-1:0]         out_char,
  output logic                      out_last,
  output logic                      out_ok
);

  cfg_t      cfg_r;
  conv_res_t conv_res;
  logic      conv_valid;
  logic      conv_take;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pad_mode    <= 1'b0;
      cfg_r.field_width <= '0;
      cfg_r.buffer_size <= BUFFER_SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_PAD_MODE:    cfg_r.pad_mode    <= cfg_data[0];
        CFG_IDX_FIELD_WIDTH: cfg_r.field_width <= cfg_data[FW_W-1:0];
        CFG_IDX_BUFFER_SIZE: cfg_r.buffer_size <= cfg_data[BUF_W-1:0];
        default:             cfg_r             <= cfg_r;
      endcase
    end
  end

  ipda_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_value  (in_value),
    .res_valid (conv_valid),
    .res_take  (conv_take),
    .res       (conv_res)
  );

  ipda_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .res_valid (conv_valid),
    .res_take  (conv_take),
    .res       (conv_res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .out_last  (out_last),
    .out_ok    (out_ok)
  );

endmodule

FILE: sv/ipda_conv.sv
// Binary to BCD converter: shift-and-add-3, four magnitude bits per cycle.
// Depends on ipda_pkg.
module ipda_conv
  import ipda_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                      res_valid,
  input  logic                      res_take,
  output conv_res_t                 res
);

  conv_state_t             state_r, state_nxt;
  logic [STEP_CNT_W-1:0]   cnt_r;
  logic [VALUE_W-1:0]      mag_r;
  bcd_t                    bcd_r;
  logic                    neg_r;
  logic [VALUE_W-1:0]      raw;
  logic [VALUE_W-1:0]      mag_in;
  bcd_t                    bcd_step;
  logic [VALUE_W-1:0]      mag_step;
  logic                    accept;

  // Magnitude of the input; the most negative value wraps to its own magnitude.
  assign raw    = in_value;
  assign mag_in = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;

  // Four dependent adjust-and-shift steps on the ten BCD digits.
  always_comb begin
    bcd_step = bcd_r;
    mag_step = mag_r;
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      for (int d = 0; d < NDIGITS; d++) begin
        if (bcd_step[d] >= DIGIT_W'(5)) begin
          bcd_step[d] = bcd_step[d] + DIGIT_W'(3);
        end
      end
      {bcd_step, mag_step} = {bcd_step, mag_step} << 1;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CV_IDLE: begin
        if (in_valid) state_nxt = CV_RUN;
      end
      CV_RUN: begin
        if (cnt_r == STEP_CNT_W'(CONV_STEPS - 1)) state_nxt = CV_DONE;
      end
      CV_DONE: begin
        if (res_take) state_nxt = CV_IDLE;
      end
      default: state_nxt = CV_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_stall  = 1'b1;
    res_valid = 1'b0;
    case (state_r)
      CV_IDLE: in_stall  = 1'b0;
      CV_RUN:  in_stall  = 1'b1;
      CV_DONE: res_valid = 1'b1;
      default: in_stall  = 1'b1;
    endcase
  end

  assign accept  = in_valid && !in_stall;
  assign res.neg = neg_r;
  assign res.bcd = bcd_r;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CV_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        cnt_r <= '0;
      end else if (state_r == CV_RUN) begin
        cnt_r <= cnt_r + STEP_CNT_W'(1);
      end
    end
  end

  // Datapath shift registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      neg_r <= raw[VALUE_W-1];
      mag_r <= mag_in;
      bcd_r <= '0;
    end else if (state_r == CV_RUN) begin
      mag_r <= mag_step;
      bcd_r <= bcd_step;
    end
  end

endmodule

FILE: sv/ipda_emit.sv
// Character sequencer: sizes the text, then sends sign, padding and digits, or a rejection beat.
// Depends on ipda_pkg; fed by ipda_conv.
module ipda_emit
  import ipda_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              res_valid,
  output logic              res_take,
  input  conv_res_t         res,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_last,
  output logic              out_ok
);

  emit_state_t          state_r, state_nxt;
  logic                 neg_r;
  bcd_t                 bcd_r;
  logic [DIGIT_W-1:0]   ndig_r;
  logic [DIGIT_W-1:0]   pos_r;
  logic                 out_valid_r;
  logic [CHAR_W-1:0]    out_char_r;
  logic                 out_last_r;
  logic                 out_ok_r;

  logic [DIGIT_W-1:0]   ndig_c;
  logic [DIGIT_W-1:0]   wsat_c;
  logic [DIGIT_W-1:0]   total_c;
  logic [DIGIT_W:0]     need_c;
  logic                 reject_c;
  logic                 out_free;
  logic                 load;
  logic [CHAR_W-1:0]    ch_nxt;
  logic                 last_nxt;
  logic                 ok_nxt;
  logic [DIG_IDX_W-1:0] dig_idx;
  logic [CHAR_W-1:0]    pad_ch;

  // Text sizing: digit count, saturated width and the capacity check.
  always_comb begin
    ndig_c = DIGIT_W'(1);
    for (int d = 0; d < NDIGITS; d++) begin
      if (bcd_r[d] != '0) ndig_c = DIGIT_W'(d + 1);
    end
    wsat_c   = (cfg.field_width > MAX_FIELD) ? MAX_FIELD : cfg.field_width;
    total_c  = (wsat_c > ndig_c) ? wsat_c : ndig_c;
    need_c   = {1'b0, total_c} + {{DIGIT_W{1'b0}}, neg_r};
    reject_c = (cfg.buffer_size == '0) ||
               ({{(BUF_W-DIGIT_W-1){1'b0}}, need_c} > (cfg.buffer_size - BUF_W'(1)));
  end

  assign out_free = !out_valid_r || !out_stall;
  assign dig_idx  = DIG_IDX_W'(pos_r - DIGIT_W'(1));
  assign pad_ch   = cfg.pad_mode ? CH_SPACE : CH_ZERO;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      EM_IDLE: begin
        if (res_valid) state_nxt = EM_PREP;
      end
      EM_PREP: begin
        if (reject_c)   state_nxt = EM_REJ;
        else if (neg_r) state_nxt = EM_SIGN;
        else            state_nxt = EM_BODY;
      end
      EM_REJ: begin
        if (out_free) state_nxt = EM_IDLE;
      end
      EM_SIGN: begin
        if (out_free) state_nxt = EM_BODY;
      end
      EM_BODY: begin
        if (out_free && pos_r == DIGIT_W'(1)) state_nxt = EM_IDLE;
      end
      default: state_nxt = EM_IDLE;
    endcase
  end

  // Per-state outputs: take a converted value or load the next character.
  always_comb begin
    res_take = 1'b0;
    load     = 1'b0;
    ch_nxt   = CH_NUL;
    last_nxt = 1'b0;
    ok_nxt   = 1'b0;
    case (state_r)
      EM_IDLE: res_take = res_valid;
      EM_PREP: res_take = 1'b0;
      EM_REJ: begin
        load     = out_free;
        ch_nxt   = CH_NUL;
        last_nxt = 1'b1;
        ok_nxt   = 1'b0;
      end
      EM_SIGN: begin
        load   = out_free;
        ch_nxt = CH_MINUS;
        ok_nxt = 1'b1;
      end
      EM_BODY: begin
        load     = out_free;
        ch_nxt   = (pos_r > ndig_r) ? pad_ch
                                    : (CH_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, bcd_r[dig_idx]});
        last_nxt = (pos_r == DIGIT_W'(1));
        ok_nxt   = 1'b1;
      end
      default: res_take = 1'b0;
    endcase
  end

  // Control state and the output beat's valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= EM_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: captured value, position counter and output character.
  always_ff @(posedge clk) begin
    if (res_take) begin
      neg_r <= res.neg;
      bcd_r <= res.bcd;
    end
    if (state_r == EM_PREP) begin
      ndig_r <= ndig_c;
      pos_r  <= total_c;
    end else if (load && state_r == EM_BODY) begin
      pos_r <= pos_r - DIGIT_W'(1);
    end
    if (load) begin
      out_char_r <= ch_nxt;
      out_last_r <= last_nxt;
      out_ok_r   <= ok_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;
  assign out_ok    = out_ok_r;

endmodule

FILE: sv/ipda_checker.sv
// Port-level checks on the output channel of the decimal ASCII formatter.
// Depends on ipda_pkg and the macro header; bound to the top level below.
`include "int_to_padded_decimal_ascii_macros.svh"

module ipda_checker
  import ipda_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [CHAR_W-1:0] out_char,
  input logic              out_last,
  input logic              out_ok
);

  // A rejection is always a single zero character.
  `IPDA_ASSERT_NOW(a_reject_form, out_valid && !out_ok, out_last && out_char == CH_NUL, "rejection beat is malformed")

  // Produced text holds only digits, the sign and the space pad.
  `IPDA_ASSERT_NOW(a_char_set, out_valid && out_ok, (out_char >= CH_ZERO && out_char <= (CH_ZERO + 8'd9)) || out_char == CH_MINUS || out_char == CH_SPACE, "unexpected character in text")

  // The sign is never the final character of a run.
  `IPDA_ASSERT_NOW(a_sign_not_last, out_valid && out_char == CH_MINUS, !out_last, "sign ends a run")

  // A stalled beat stays put.
  `IPDA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_char) && $stable(out_last) && $stable(out_ok), "stalled output beat changed")

endmodule

bind int_to_padded_decimal_ascii ipda_checker u_ipda_checker (.*);
